/* hw/rtl/crgn_pkg.sv */
`default_nettype none
package crgn_pkg;
    localparam int MAX_COLUMNS = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W = 33;

    // word handed from front to back: a coefficient plus row markers
    typedef struct packed {
        logic [DATA_W-1:0] coef;
        logic              first;
        logic              last;
        logic              keep;
    } t_q_word;

    // magnitude of a 32-bit signed value, 2^31 for the most negative
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] r;
        r = x[DATA_W-1] ? (~x + 32'd1) : x;
        return r;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/crgn_front.sv */
`default_nettype none
// Input stage: registers one word and marks row start, end and overflow drops.
module crgn_front #(
    parameter int MAX_COLS = crgn_pkg::MAX_COLUMNS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [31:0]           i_coef,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output crgn_pkg::t_q_word          o_word
);
    localparam int CW = $clog2(MAX_COLS + 1);
    logic [CW-1:0] r_cnt;
    logic          r_valid;
    crgn_pkg::t_q_word r_word;
    logic          acc;

    assign o_ready = !r_valid || i_ready;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (acc) begin
                r_valid <= 1'b1;
                if (i_last) r_cnt <= '0;
                else if (r_cnt < CW'(MAX_COLS)) r_cnt <= r_cnt + CW'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_word.coef  <= i_coef;
            r_word.first <= (r_cnt == '0);
            r_word.last  <= i_last;
            r_word.keep  <= (r_cnt < CW'(MAX_COLS));
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/crgn_queue.sv */
`default_nettype none
// Two-entry queue between front and back.
module crgn_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  crgn_pkg::t_q_word  i_word,
    output logic               o_valid,
    input  wire logic          i_ready,
    output crgn_pkg::t_q_word  o_word
);
    crgn_pkg::t_q_word r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_word;
    end
endmodule
`default_nettype wire

/* hw/rtl/crgn_back.sv */
`default_nettype none
// Row engine: stores entries, folds gcd by shared restoring divider, emits row.
module crgn_back #(
    parameter int MAX_COLS = crgn_pkg::MAX_COLUMNS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_bounds,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  crgn_pkg::t_q_word  i_word,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_coef,
    output logic               o_last,
    output logic               o_changed
);
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(MAX_COLS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_st;
    logic [31:0] r_mem [MAX_COLS];
    logic [31:0] r_rd;
    logic [NW-1:0] r_n;
    logic [AW-1:0] r_k;
    logic [31:0] r_g;
    logic        r_end;     // gcd started at row end (constant fold)
    logic        r_end_done;
    logic        r_bounds;
    logic [31:0] r_c0;      // constant term of the current row
    // shared divider: r_a mod/div r_b
    logic [31:0] r_a, r_b, r_q;
    logic [32:0] r_rem;
    logic [5:0]  r_i;
    logic        r_neg;
    logic        r_changed;
    logic        r_ov;
    logic [31:0] r_oc;
    logic        r_ol;
    logic        r_ochg;
    logic [32:0] trial;
    logic        emit;

    assign o_ready   = (r_st == S_IDLE);
    assign o_valid   = r_ov;
    assign o_coef    = r_oc;
    assign o_last    = r_ol;
    assign o_changed = r_ochg;
    assign trial = {r_rem[31:0], r_a[31]} - {1'b0, r_b};
    // output register loads when the quotient is ready and the slot is free
    assign emit = (r_st == S_DIV) && (r_i == 6'd40) && (!r_ov || i_ready);

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid && i_word.keep)
            r_mem[i_word.first ? '0 : AW'(r_n)] <= i_word.coef;
        r_rd <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_n <= '0;
            r_g <= '0;
            r_end_done <= 1'b0;
        end else begin
            if (emit) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    logic [NW-1:0] n1;
                    logic [31:0] m;
                    n1 = i_word.first ? NW'(0) : r_n;
                    m = crgn_pkg::mag(i_word.coef);
                    if (i_word.keep) n1 = n1 + NW'(1);
                    r_n <= n1;
                    r_bounds <= i_bounds;
                    r_end <= i_word.last;
                    if (i_word.first) begin
                        r_g <= '0;
                        r_c0 <= i_word.coef;
                    end
                    if (i_word.keep && !i_word.first && m != 0) begin
                        if (!i_word.first && r_g == 0) begin
                            r_g <= m;
                            r_st <= i_word.last ? S_FIN : S_IDLE;
                        end else begin
                            r_a <= r_g; r_b <= m; r_rem <= '0; r_i <= '0;
                            r_st <= S_GCD;
                        end
                    end else if (i_word.last) r_st <= S_FIN;
                end
                S_GCD: begin
                    // one quotient bit per cycle; at the end r_rem holds a % b
                    if (r_i == 6'd32) begin
                        if (r_rem[31:0] == 0) begin
                            r_g <= r_b;
                            r_st <= r_end ? S_FIN : S_IDLE;
                        end else begin
                            r_a <= r_b; r_b <= r_rem[31:0];
                            r_rem <= '0; r_i <= '0;
                        end
                    end else begin
                        if (trial[32]) r_rem <= {r_rem[31:0], r_a[31]};
                        else           r_rem <= trial;
                        r_a <= {r_a[30:0], 1'b0};
                        r_i <= r_i + 6'd1;
                    end
                end
                S_FIN: begin
                    // fold the constant in plain mode, then start emission
                    logic [31:0] m0;
                    m0 = crgn_pkg::mag(r_c0);
                    if (!r_bounds && r_n != 0 && m0 != 0 && !r_end_done) begin
                        r_end_done <= 1'b1;
                        if (r_g == 0) r_g <= m0;
                        else begin
                            r_a <= r_g; r_b <= m0; r_rem <= '0; r_i <= '0;
                            r_st <= S_GCD;
                        end
                    end else begin
                        r_end_done <= 1'b0;
                        r_k <= '0;
                        r_changed <= 1'b0;
                        r_st <= (r_n == 0) ? S_IDLE : S_RD;
                    end
                end
                S_RD: begin
                    r_st <= S_DIV;
                    r_i <= 6'd63;
                end
                S_DIV: begin
                    if (r_i == 6'd63) begin
                        r_neg <= r_rd[31];
                        r_a <= crgn_pkg::mag(r_rd);
                        r_b <= r_g; r_rem <= '0;
                        if (r_g <= 32'd1) begin
                            r_q <= r_rd; r_i <= 6'd40;
                        end else begin
                            r_q <= '0; r_i <= '0;
                        end
                    end else if (r_i == 6'd40) begin
                        if (emit) begin
                            r_oc <= r_q;
                            r_ol <= (NW'(r_k) + NW'(1) == r_n);
                            r_ochg <= r_changed;
                            if (NW'(r_k) + NW'(1) == r_n) r_st <= S_IDLE;
                            else begin
                                r_k <= r_k + AW'(1);
                                r_st <= S_RD;
                            end
                        end
                    end else if (r_i == 6'd32) begin
                        logic [31:0] q;
                        logic ex;
                        ex = (r_rem[31:0] == 0);
                        q = r_neg ? (~r_q + 32'd1) : r_q;
                        if (r_bounds && r_k == '0 && !ex) begin
                            r_changed <= 1'b1;
                            if (r_neg) q = q - 32'd1;
                        end
                        r_q <= q;
                        r_i <= 6'd40;
                    end else begin
                        if (trial[32]) begin
                            r_rem <= {r_rem[31:0], r_a[31]};
                            r_q <= {r_q[30:0], 1'b0};
                        end else begin
                            r_rem <= trial;
                            r_q <= {r_q[30:0], 1'b1};
                        end
                        r_a <= {r_a[30:0], 1'b0};
                        r_i <= r_i + 6'd1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/constraint_row_gcd_normalize.sv */
`default_nettype none
// Path: an accepted word passes the front register and the queue before the back engine,
// then each Euclid remainder step runs on the shared radix-2 divider.
// Emission after the last word: the divisor is settled (plus constant gcd steps), then each
// stored entry is divided, or passed through unchanged when the divisor is at most 1.
// Flow: one row at a time in the back; front keeps taking words until the queue is full.
// Reset: i_rst_n synchronous active low; clears control, gcd, count and bounds_mode.
module constraint_row_gcd_normalize #(
    parameter int MAX_COLUMNS = crgn_pkg::MAX_COLUMNS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // coefficient
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // scaled_coefficient
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // constant_changed
);
    logic r_bounds;
    logic f_v, f_r, q_v, q_r;
    crgn_pkg::t_q_word f_w, q_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bounds <= 1'b0;
        else if (i_cfg_we) r_bounds <= i_cfg_wdata;
    end

    crgn_front #(.MAX_COLS(MAX_COLUMNS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_coef(s_axis_tdata), .i_last(s_axis_tlast),
        .o_valid(f_v), .i_ready(f_r), .o_word(f_w));

    crgn_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_word(f_w),
        .o_valid(q_v), .i_ready(q_r), .o_word(q_w));

    crgn_back #(.MAX_COLS(MAX_COLUMNS)) u_back (
        .i_clk, .i_rst_n, .i_bounds(r_bounds),
        .i_valid(q_v), .o_ready(q_r), .i_word(q_w),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_coef(m_axis_tdata), .o_last(m_axis_tlast), .o_changed(m_axis_tuser));

    a_flag_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> $past(r_bounds, 1) || r_bounds)
        else $error("changed flag outside bounds mode");
    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_v && !f_r && !q_v))
        else $error("queue state");
endmodule
`default_nettype wire

/* sim/constraint_row_gcd_normalize_tb.sv */
module constraint_row_gcd_normalize_tb;

    localparam int NCOL      = crgn_pkg::MAX_COLUMNS;
    localparam int CYC_LIMIT = 1000000;
    localparam int SETTLE    = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // coefficient
    logic        s_axis_tlast = 1'b0;  // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // scaled_coefficient
    logic        m_axis_tlast;         // last_out
    logic        m_axis_tuser;         // constant_changed

    constraint_row_gcd_normalize DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic [31:0] coef;
        logic        last;
        logic        chg;
    } t_scaled;

    // model copy of the block
    logic [31:0] row_mem [NCOL];
    logic [31:0] row_gcd;
    int          row_len;
    logic        mode_bounds;

    t_scaled scaled_q[$];
    int      errors = 0;
    int      cycles = 0;
    bit      quiet = 0;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [31:0] gcd_fold(input logic [31:0] g, input logic [31:0] m);
        logic [31:0] a, b, r;
        if (m == 0) return g;
        if (g == 0) return m;
        a = g;
        b = m;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // take one accepted word; on last, queue the normalized row
    task automatic absorb_word(input logic [31:0] c, input logic lst);
        logic [31:0] g;
        longint      v, d, q;
        logic        chg;
        t_scaled     w;
        if (row_len < NCOL) begin
            row_mem[row_len] = c;
            if (row_len != 0) row_gcd = gcd_fold(row_gcd, abs32(c));
            row_len++;
        end
        if (lst) begin
            g = row_gcd;
            chg = 1'b0;
            if (!mode_bounds && row_len > 0) g = gcd_fold(g, abs32(row_mem[0]));
            if (g > 1 && mode_bounds) begin
                v = longint'($signed(row_mem[0]));
                d = longint'({32'd0, g});
                if ((v / d) * d != v) chg = 1'b1;
            end
            for (int k = 0; k < row_len; k++) begin
                v = longint'($signed(row_mem[k]));
                q = v;
                if (g > 1) begin
                    d = longint'({32'd0, g});
                    q = v / d;
                    if (mode_bounds && k == 0 && q * d != v && v < 0) q = q - 1;
                end
                w.coef = q[31:0];
                w.last = (k + 1 == row_len);
                w.chg  = chg;
                scaled_q.push_back(w);
            end
            row_len = 0;
            row_gcd = '0;
        end
    endtask

    task automatic note_mismatch(input string what, input t_scaled e, input t_scaled a);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected coef=%0d last=%0b chg=%0b, got coef=%0d last=%0b chg=%0b",
                     what, $signed(e.coef), e.last, e.chg, $signed(a.coef), a.last, a.chg);
    endtask

    // output side: random stalls, compare each word against the oldest prediction
    int stall = 0;
    always @(posedge i_clk) begin
        t_scaled got, exp_w;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
            if (scaled_q.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                exp_w = scaled_q.pop_front();
                if (got !== exp_w) note_mismatch("result", exp_w, got);
            end
            stall = quiet ? 0 : $urandom_range(0, 16);
            m_axis_tready <= (stall == 0);
        end else if (stall > 0) begin
            stall = stall - 1;
            m_axis_tready <= (stall == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles >= CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] c, input logic lst);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        absorb_word(c, lst);
    endtask

    // drain everything, then let the back engine go quiet before a write
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_bounds = m;
    endtask

    // directed rows; chk rows carry a hand-computed result per word
    typedef struct {
        logic        mode;
        int          coef;
        logic        last;
        logic        chk;
        int          exp_coef;
        logic        exp_chg;
    } t_row_item;

    t_row_item dir_tab[] = '{
        '{0,  6,          0, 1,  3, 0},
        '{0,  4,          0, 1,  2, 0},
        '{0, -8,          1, 1, -4, 0},
        '{0,  5,          1, 1,  1, 0},   // lone constant, plain mode
        '{0,  0,          0, 1,  0, 0},   // no non-zero entry
        '{0,  0,          1, 1,  0, 0},
        '{0,  7,          0, 1,  7, 0},   // gcd of one
        '{0,  3,          1, 1,  3, 0},
        '{0,  2147483647, 0, 1,  1, 0},   // extremes
        '{0, -2147483647, 1, 1, -1, 0},
        '{1,  7,          0, 1,  1, 1},   // inexact positive constant
        '{1,  4,          0, 1,  1, 1},
        '{1, -8,          1, 1, -2, 1},
        '{1, -7,          0, 1, -2, 1},   // inexact negative constant, floor
        '{1,  4,          0, 1,  1, 1},
        '{1,  8,          1, 1,  2, 1},
        '{1,  8,          0, 1,  2, 0},   // exact constant
        '{1,  4,          1, 1,  1, 0},
        '{1,  5,          1, 1,  5, 0},   // lone constant, bounds mode
        '{1, -2147483647, 0, 1, -2147483647, 0},
        '{1,  0,          1, 1,  0, 0}
    };

    initial begin
        int      k, n, len, f, nrand, base;
        logic    m;
        t_scaled w;
        row_len = 0;
        row_gcd = '0;
        mode_bounds = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        k = 0;
        n = 0;
        while (k < dir_tab.size()) begin
            if (row_len == 0 && dir_tab[k].mode != mode_bounds) write_mode(dir_tab[k].mode);
            send_word(dir_tab[k].coef, dir_tab[k].last);
            n++;
            if (dir_tab[k].last) begin
                base = scaled_q.size() - n;
                for (int j = 0; j < n; j++) begin
                    w = scaled_q[base + j];
                    if (dir_tab[k - n + 1 + j].chk &&
                        (w.coef !== dir_tab[k - n + 1 + j].exp_coef[31:0] ||
                         w.chg !== dir_tab[k - n + 1 + j].exp_chg))
                        note_mismatch("table",
                            '{dir_tab[k-n+1+j].exp_coef[31:0], w.last, dir_tab[k-n+1+j].exp_chg},
                            w);
                end
                n = 0;
            end
            k++;
        end

        // random rows, mostly sharing a common factor
        nrand = 0;
        while (nrand < 110) begin
            if ($urandom_range(0, 3) == 0) begin
                m = $urandom_range(0, 1);
                write_mode(m);
            end
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(17, 20);   // overlong row
                1:       len = NCOL;
                default: len = $urandom_range(1, 8);
            endcase
            f = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
                int c;
                case ($urandom_range(0, 9))
                    0:       c = $urandom;
                    1:       c = 0;
                    2:       c = $urandom_range(0, 1) ? 2147483647 : -2147483647;
                    default: c = f * ($signed($urandom_range(0, 65534)) - 32767);
                endcase
                if (c == 32'sh80000000) c = 0;
                if (j == 0 && $urandom_range(0, 2) == 0) c = $signed($urandom_range(0, 200)) - 100;
                send_word(c, j == len - 1);
                nrand++;
            end
        end
        quiet = 0;

        wait_idle();
        if (errors == 0 && scaled_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
